### src/des_rf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round function package
// Bit selection tables for the E expansion and the P permutation, and the
// contents of the eight standard S-boxes.
// ----------------------------------------------------------------------------
package des_rf_pkg;

   // Field widths.
   localparam int HalfWidth  = 32;
   localparam int KeyWidth   = 48;
   localparam int NumBoxes   = 8;
   localparam int BoxInWidth = 6;
   localparam int BoxOutWidth = 4;

   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [KeyWidth-1:0]  key_type;

   // Source bit (vector index, 0 is least significant) of each expanded bit.
   // Entry 0 gives the most significant expanded bit.
   localparam logic [4:0] E_SRC [KeyWidth] = '{
      5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd28, 5'd27,
      5'd26, 5'd25, 5'd24, 5'd23, 5'd24, 5'd23, 5'd22, 5'd21,
      5'd20, 5'd19, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
      5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd12, 5'd11,
      5'd10, 5'd9,  5'd8,  5'd7,  5'd8,  5'd7,  5'd6,  5'd5,
      5'd4,  5'd3,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
   };

   // Source bit of each permuted bit, entry 0 gives the most significant bit.
   localparam logic [4:0] P_SRC [HalfWidth] = '{
      5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
      5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
      5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
      5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
   };

   // S-box contents, addressed by {row, column}.
   localparam logic [3:0] SBOX [NumBoxes][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
   };

   // Handshake state between the input stage and the result stage.
   typedef struct packed {
      logic in_full;
      logic out_full;
      logic out_stall;
   } pipe_ctl_type;

endpackage

### src/des_rf_sbox_layer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES S-box layer
// Splits the 48-bit key-mixed word into eight 6-bit groups and looks each
// up in its S-box, first group and S1 at the most significant end.
// ----------------------------------------------------------------------------
module des_rf_sbox_layer (
   input  des_rf_pkg::key_type  mixed,
   output des_rf_pkg::half_type subst
);

   // Outer bits pick the row, middle bits pick the column.
   always_comb begin
      logic [5:0] six;
      subst = '0;
      for (int g = 0; g < des_rf_pkg::NumBoxes; g++) begin
         six = mixed[des_rf_pkg::KeyWidth - 1 - des_rf_pkg::BoxInWidth * g -:
                     des_rf_pkg::BoxInWidth];
         subst[des_rf_pkg::HalfWidth - 1 - des_rf_pkg::BoxOutWidth * g -:
               des_rf_pkg::BoxOutWidth] = des_rf_pkg::SBOX[g][{six[5], six[0], six[4:1]}];
      end
   end

endmodule

### src/des_rf_f_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES f function datapath
// Expansion, key mix, S-box layer and P permutation, all combinational.
// ----------------------------------------------------------------------------
module des_rf_f_logic (
   input  des_rf_pkg::half_type right_half,
   input  des_rf_pkg::key_type  round_key,
   output des_rf_pkg::half_type f_output
);

   des_rf_pkg::key_type  expanded;
   des_rf_pkg::key_type  mixed;
   des_rf_pkg::half_type subst;

   // The E table duplicates the edge bits of each nibble.
   always_comb begin
      for (int i = 0; i < des_rf_pkg::KeyWidth; i++) begin
         expanded[des_rf_pkg::KeyWidth - 1 - i] = right_half[des_rf_pkg::E_SRC[i]];
      end
   end

   assign mixed = expanded ^ round_key;

   des_rf_sbox_layer u_sbox (
      .mixed (mixed),
      .subst (subst)
   );

   // The P permutation is a fixed rewiring of the S-box outputs.
   always_comb begin
      for (int i = 0; i < des_rf_pkg::HalfWidth; i++) begin
         f_output[des_rf_pkg::HalfWidth - 1 - i] = subst[des_rf_pkg::P_SRC[i]];
      end
   end

endmodule

### src/des_round_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round function
// Computes f(R, K) = P(S(E(R) xor K)) with an input register and a result
// register around the combinational datapath.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                                 | Handshake
//  req     | in        | req_right_half, req_round_key         | req_valid / req_stall
//  rsp     | out       | rsp_f_output                          | rsp_valid / rsp_stall
//
// One transaction is accepted every cycle while req_stall is low; each passes
// through the input register and then the result register.
// Reset clears both stage valid bits and holds req_stall high.
// A result stall backs up into the input stage only once both stages hold
// a transaction, so one more transaction is taken while a result waits.
// ----------------------------------------------------------------------------
module des_round_function (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  des_rf_pkg::half_type req_right_half,
   input  des_rf_pkg::key_type  req_round_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output des_rf_pkg::half_type rsp_f_output
);

   des_rf_pkg::pipe_ctl_type ctl;

   logic                 in_valid_ff, in_valid_in;
   des_rf_pkg::half_type half_ff;
   des_rf_pkg::key_type  key_ff;
   logic                 out_valid_ff, out_valid_in;
   des_rf_pkg::half_type f_ff, f_in;
   logic                 out_load;
   logic                 in_load;

   assign ctl.in_full   = in_valid_ff;
   assign ctl.out_full  = out_valid_ff;
   assign ctl.out_stall = rsp_stall;

   // The result stage loads when it is empty or its transaction leaves.
   assign out_load  = !ctl.out_full || !ctl.out_stall;
   assign req_stall = reset || (ctl.in_full && !out_load);
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_load || (ctl.in_full && !out_load);
      out_valid_in = out_load ? ctl.in_full : ctl.out_full;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (in_load) begin
         half_ff <= req_right_half;
         key_ff  <= req_round_key;
      end
   end

   des_rf_f_logic u_f (
      .right_half (half_ff),
      .round_key  (key_ff),
      .f_output   (f_in)
   );

   // Result payload register.
   always_ff @(posedge clock) begin
      if (out_load && ctl.in_full) begin
         f_ff <= f_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_f_output = f_ff;

endmodule

### src/des_rf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round function checker
// Port-level checks on reset, stall behavior and flow-through latency.
// ----------------------------------------------------------------------------
module des_rf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input des_rf_pkg::half_type rsp_f_output
);

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_f_output))
      else $error("stalled result changed");

   // The input side only backs up in reset or when the result is stalled.
   assert property (@(posedge clock) req_stall |-> rsp_stall || reset)
      else $error("input stalled without a result stall");

   // An accepted transaction reaches the result port via both registers.
   assert property (@(posedge clock)
      (req_valid && !req_stall && !reset) ##1 (!rsp_stall && !reset) |=> rsp_valid)
      else $error("transaction did not reach the result port");

endmodule

bind des_round_function des_rf_checker u_des_rf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_f_output (rsp_f_output)
);
